// ===== sv/mrm_pkg.sv =====
`timescale 1ns / 1ps

package mrm_pkg;

    // Default matrix dimension held in the on-chip stores.
    localparam int MAX_DIM_DEFAULT = 16;

    // Field widths fixed by the item format.
    localparam int SIZE_W    = 5;
    localparam int IDX_W     = 4;
    localparam int VAL_W     = 32;
    localparam int ACTION_W  = 2;
    localparam int FRAC_W    = 16;
    localparam int FIELD_CAP = 16;

    // Configuration port.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECTED_ROW = 1'b1;
    localparam logic [SIZE_W-1:0]    SIZE_RESET       = 5'd16;
    localparam logic [IDX_W-1:0]     ROW_RESET        = 4'd0;

    // Saturation limits of signed Q16.16.
    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_A  = 2'd0,
        ACT_LOAD_B  = 2'd1,
        ACT_COMPUTE = 2'd2
    } mrm_action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_FINISH
    } mrm_state_t;

endpackage

// ===== sv/mrm_cmd_if.sv =====
`timescale 1ns / 1ps

interface mrm_cmd_if;
    import mrm_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [IDX_W-1:0]    row_index;
    logic [IDX_W-1:0]    col_index;
    logic signed [VAL_W-1:0] element_value;

    modport source (output valid, action, row_index, col_index, element_value, input ready);
    modport sink   (input valid, action, row_index, col_index, element_value, output ready);
endinterface

// ===== sv/mrm_result_if.sv =====
`timescale 1ns / 1ps

interface mrm_result_if;
    import mrm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        result_column;
    logic signed [VAL_W-1:0] result_value;
    logic                    saturated;
    logic                    row_error;
    logic                    last;

    modport source (output valid, result_column, result_value, saturated, row_error, last,
                    input ready);
    modport sink   (input valid, result_column, result_value, saturated, row_error, last,
                    output ready);
endinterface

// ===== sv/matrix_row_times_matrix_unit.sv =====
`timescale 1ns / 1ps

// Channel   Role    Handshake      Payload
// cmd       sink    valid/ready    action, row_index, col_index, element_value
// result    source  valid/ready    result_column, result_value, saturated, row_error, last
// cfg       write   cfg_we         cfg_index, cfg_data
//
// A load item is taken whenever the unit is idle, and loads may follow each other in every cycle.
// For a compute item of size n, each column of the product row streams n multiply-accumulates
// through the single 32x32 multiplier, fed by one read port on each store, then waits for
// the pipeline to drain. A compute with a row error skips the multiplies and yields a
// single error result. Reset (rst_n low) clears all control
// state and restores the register defaults; the element stores are not cleared.
// A stalled result holds the sequencer at the end of a column, and cmd is not
// ready until the whole row has been handed to the result register.
module matrix_row_times_matrix_unit #(
    parameter int MAX_DIM = mrm_pkg::MAX_DIM_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrm_pkg::SIZE_W-1:0]     cfg_data,
    mrm_cmd_if.sink                        cmd,
    mrm_result_if.source                   result
);
    import mrm_pkg::*;

    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int AW      = $clog2(DEPTH);
    localparam int N_CAP   = (MAX_DIM < FIELD_CAP) ? MAX_DIM : FIELD_CAP;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int ACC_W   = PROD_W + $clog2(MAX_DIM);
    localparam int TOP_LSB = FRAC_W + VAL_W - 1;

    // Stores are addressed row * MAX_DIM + column, as laid out in memory.
    function automatic logic [AW-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
        return AW'(int'(r) * MAX_DIM + int'(c));
    endfunction

    // Configuration registers.
    logic [SIZE_W-1:0] matrix_size_reg;
    logic [IDX_W-1:0]  selected_row_reg;
    logic [SIZE_W-1:0] size_eff;

    // Sequencer state.
    mrm_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [SIZE_W-1:0] n_reg, n_next;
    logic              err_reg, err_next;

    // Datapath pipeline: memory read, multiply, accumulate.
    logic                     v1_reg, v2_reg;
    logic                     first1_reg, first2_reg;
    logic signed [VAL_W-1:0]  a_rdata_reg, b_rdata_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // Element stores.
    logic [VAL_W-1:0] mem_a [DEPTH];
    logic [VAL_W-1:0] mem_b [DEPTH];
    logic [AW-1:0]    wr_addr, a_raddr, b_raddr;
    logic             a_we, b_we;

    // Result register.
    logic                    out_valid_reg;
    logic [IDX_W-1:0]        out_col_reg;
    logic signed [VAL_W-1:0] out_val_reg;
    logic                    out_sat_reg;
    logic                    out_err_reg;
    logic                    out_last_reg;

    logic        cmd_fire, cmd_ready, in_range, row_err_now;
    logic        j_last, i_last, pipe_empty, slot_free, emit, issue, load_out;
    mrm_action_t act;
    logic [ACC_W-1:TOP_LSB] acc_top;
    logic                   acc_ovf;
    logic [VAL_W-1:0]       sum_val;

    // The size in use is capped at the store dimension and at the index range.
    assign size_eff = (matrix_size_reg > SIZE_W'(N_CAP)) ? SIZE_W'(N_CAP) : matrix_size_reg;

    assign act         = mrm_action_t'(cmd.action);
    assign cmd_fire    = cmd.valid && cmd_ready;
    assign in_range    = ({1'b0, cmd.row_index} < size_eff) && ({1'b0, cmd.col_index} < size_eff);
    assign row_err_now = ({1'b0, selected_row_reg} >= size_eff);

    assign j_last     = ({1'b0, j_reg} == n_reg - 1'b1);
    assign i_last     = ({1'b0, i_reg} == n_reg - 1'b1);
    assign pipe_empty = !v1_reg && !v2_reg;
    assign slot_free  = !out_valid_reg || result.ready;
    assign emit       = (state_reg == ST_FINISH) && pipe_empty && slot_free;

    assign wr_addr = elem_addr(cmd.row_index, cmd.col_index);
    assign a_raddr = elem_addr(selected_row_reg, j_reg);
    assign b_raddr = elem_addr(j_reg, i_reg);

    // Truncation drops the low fraction bits of the exact sum; anything left in the
    // bits above the Q16.16 word that is not a copy of its sign is an overflow.
    assign acc_top = acc_reg[ACC_W-1:TOP_LSB];
    assign acc_ovf = !((&acc_top) || !(|acc_top));
    assign sum_val = acc_ovf ? (acc_reg[ACC_W-1] ? VAL_MIN : VAL_MAX)
                             : acc_reg[TOP_LSB:FRAC_W];

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_size_reg  <= SIZE_RESET;
            selected_row_reg <= ROW_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_MATRIX_SIZE)
                matrix_size_reg <= cfg_data;
            else if (cfg_index == CFG_SELECTED_ROW)
                selected_row_reg <= cfg_data[IDX_W-1:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && act == ACT_COMPUTE)
                    state_next = row_err_now ? ST_FINISH : ST_ISSUE;
            end
            ST_ISSUE:
            begin
                if (j_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (emit)
                    state_next = (err_reg || i_last) ? ST_IDLE : ST_ISSUE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        cmd_ready = 1'b0;
        a_we      = 1'b0;
        b_we      = 1'b0;
        issue     = 1'b0;
        load_out  = 1'b0;
        i_next    = i_reg;
        j_next    = j_reg;
        n_next    = n_reg;
        err_next  = err_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_fire)
                begin
                    unique case (act)
                        ACT_LOAD_A:  a_we = in_range;
                        ACT_LOAD_B:  b_we = in_range;
                        ACT_COMPUTE:
                        begin
                            n_next   = size_eff;
                            err_next = row_err_now;
                            i_next   = '0;
                            j_next   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ISSUE:
            begin
                issue  = 1'b1;
                j_next = j_last ? '0 : j_reg + 1'b1;
            end
            ST_FINISH:
            begin
                if (emit)
                begin
                    load_out = 1'b1;
                    i_next   = i_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            err_reg       <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            first1_reg    <= 1'b0;
            first2_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            n_reg      <= n_next;
            err_reg    <= err_next;
            v1_reg     <= issue;
            first1_reg <= issue && (j_reg == '0);
            v2_reg     <= v1_reg;
            first2_reg <= first1_reg;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Element stores: one write port and one registered read port each.
    always_ff @(posedge clk)
    begin
        if (a_we)
            mem_a[wr_addr] <= cmd.element_value;
        a_rdata_reg <= mem_a[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
            mem_b[wr_addr] <= cmd.element_value;
        b_rdata_reg <= mem_b[b_raddr];
    end

    // Shared multiplier and accumulator.
    always_ff @(posedge clk)
    begin
        prod_reg <= a_rdata_reg * b_rdata_reg;
        if (v2_reg)
        begin
            if (first2_reg)
                acc_reg <= {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            else
                acc_reg <= acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_col_reg  <= err_reg ? '0 : i_reg;
            out_val_reg  <= err_reg ? '0 : sum_val;
            out_sat_reg  <= err_reg ? 1'b0 : acc_ovf;
            out_err_reg  <= err_reg;
            out_last_reg <= err_reg || i_last;
        end
    end

    assign cmd.ready            = cmd_ready;
    assign result.valid         = out_valid_reg;
    assign result.result_column = out_col_reg;
    assign result.result_value  = out_val_reg;
    assign result.saturated     = out_sat_reg;
    assign result.row_error     = out_err_reg;
    assign result.last          = out_last_reg;

`ifndef SYNTH
    // The sequencer never steps past the size latched for the current row.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ISSUE |-> ({1'b0, j_reg} < n_reg) && ({1'b0, i_reg} < n_reg))
        else $error("issue index beyond matrix size");

    // Commands are taken only once the multiply pipeline has drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> pipe_empty)
        else $error("command accepted with pipeline busy");

    // A row error is a single result that closes the row at column zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg |-> out_last_reg && out_col_reg == '0 && !out_sat_reg)
        else $error("malformed row error result");

    // A saturated result carries one of the two range limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_sat_reg |-> out_val_reg == VAL_MAX || out_val_reg == VAL_MIN)
        else $error("saturated result not at a limit");

    // Loading a result that closes the row returns the sequencer to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out && (err_reg || i_last) |=> state_reg == ST_IDLE)
        else $error("sequencer busy after last result");
`endif

endmodule
